// ----- hw/rtl/obb_pkg.sv -----
// ----------------------------------------------------------------------------
// obb_pkg: shared types and constants for the oriented box bound block
// Slot codes, fixed-point widths and the product bundle passed between the
// multiply stage and the reduction stage.
// ----------------------------------------------------------------------------
package obb_pkg;

  // Field widths
  localparam int SLOT_W      = 3;
  localparam int COMP_W      = 32;
  localparam int HALF_W      = 31;
  localparam int BASE_W      = COMP_W + 1;       // translation + position
  localparam int PROD_W      = 2 * COMP_W;       // signed center product
  localparam int HPROD_W     = 2 * COMP_W - 1;   // |a|*|b| <= 2^62
  localparam int FRAC_BITS_DEF = 16;

  // Vector store layout: three words per stored slot
  localparam int VEC_SLOTS   = 6;
  localparam int STORE_DEPTH = VEC_SLOTS * 3;

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic signed [COMP_W-1:0] comp_t;

  // Slot codes
  localparam slot_t SLOT_BASIS0 = 3'd0;
  localparam slot_t SLOT_BASIS1 = 3'd1;
  localparam slot_t SLOT_BASIS2 = 3'd2;
  localparam slot_t SLOT_TRANS  = 3'd3;
  localparam slot_t SLOT_LCTR   = 3'd4;
  localparam slot_t SLOT_HALF   = 3'd5;
  localparam slot_t SLOT_POS    = 3'd6;
  localparam slot_t SLOT_UNUSED = 3'd7;

  // Saturation limits
  localparam logic [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};
  localparam logic [HALF_W-1:0] HALF_MAX = {HALF_W{1'b1}};

  // Registered products of one position beat
  typedef struct packed {
    logic                                degen;
    logic [2:0][COMP_W-1:0]              pos;
    logic [2:0][BASE_W-1:0]              base;       // row: translation + position
    logic [2:0][2:0][PROD_W-1:0]         ctr_prod;   // [row][col] M * local center
    logic [2:0][2:0][HPROD_W-1:0]        half_prod;  // [row][col] |M| * |half|
  } obb_prod_t;

  // Exact magnitude; the most negative value maps to 2^31
  function automatic logic [COMP_W-1:0] abs_comp(input comp_t v);
    logic [COMP_W-1:0] neg;
    neg = COMP_W'(-v);
    return v[COMP_W-1] ? neg : v;
  endfunction

endpackage

// ----- hw/rtl/obb_if.sv -----
// ----------------------------------------------------------------------------
// obb_in_if / obb_out_if: valid/ready channels of the box bound block
// One vector beat in, one bounding box beat out.
// ----------------------------------------------------------------------------
interface obb_in_if;
  import obb_pkg::*;

  logic  valid;
  logic  ready;
  slot_t slot;
  comp_t comp_x;
  comp_t comp_y;
  comp_t comp_z;

  modport source (output valid, slot, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, slot, comp_x, comp_y, comp_z, output ready);
endinterface

interface obb_out_if;
  import obb_pkg::*;

  logic              valid;
  logic              ready;
  comp_t             box_center_x;
  comp_t             box_center_y;
  comp_t             box_center_z;
  logic [HALF_W-1:0] box_half_x;
  logic [HALF_W-1:0] box_half_y;
  logic [HALF_W-1:0] box_half_z;
  logic              degenerate;

  modport source (output valid, box_center_x, box_center_y, box_center_z,
                  box_half_x, box_half_y, box_half_z, degenerate, input ready);
  modport sink   (input valid, box_center_x, box_center_y, box_center_z,
                  box_half_x, box_half_y, box_half_z, degenerate, output ready);
endinterface

// ----- hw/rtl/obb_prod.sv -----
// ----------------------------------------------------------------------------
// obb_prod: input register, vector store and product stage
// Stores basis, translation, local center and half extent beats; a position
// beat reads the whole store and registers the nine signed and nine
// magnitude products.
// ----------------------------------------------------------------------------
module obb_prod (
  input  logic               clk,
  input  logic               rst_n,
  obb_in_if.sink             in_ch,
  output logic               prod_valid_o,
  output obb_pkg::obb_prod_t prod_o,
  input  logic               prod_ready_i
);
  import obb_pkg::*;

  // Input register
  logic      s1_valid_r;
  slot_t     s1_slot_r;
  comp_t     s1_x_r, s1_y_r, s1_z_r;
  logic      s2_valid_r;
  obb_prod_t s2_r;
  logic      s2_ready;
  logic      s1_is_pos;
  logic      st_wr;

  comp_t     store_r [STORE_DEPTH];
  obb_prod_t prod_nxt;

  assign s2_ready    = !s2_valid_r || prod_ready_i;
  assign in_ch.ready = !s1_valid_r || s2_ready;
  assign s1_is_pos   = (s1_slot_r == SLOT_POS);
  assign st_wr       = s1_valid_r && s2_ready && (s1_slot_r < SLOT_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_slot_r <= in_ch.slot;
      s1_x_r    <= in_ch.comp_x;
      s1_y_r    <= in_ch.comp_y;
      s1_z_r    <= in_ch.comp_z;
    end
  end

  // Vector store: three words per slot, written when the beat leaves stage 1
  always_ff @(posedge clk) begin
    if (st_wr) begin
      for (int s = 0; s < VEC_SLOTS; s++) begin
        if (s1_slot_r == slot_t'(s)) begin
          store_r[3*s]     <= s1_x_r;
          store_r[3*s + 1] <= s1_y_r;
          store_r[3*s + 2] <= s1_z_r;
        end
      end
    end
  end

  // Products and degenerate check; matrix entry (r,c) sits at word 3c+r
  always_comb begin
    logic [PROD_W-1:0] hp;
    comp_t             pcomp [3];
    pcomp[0] = s1_x_r;
    pcomp[1] = s1_y_r;
    pcomp[2] = s1_z_r;
    prod_nxt = '0;
    hp       = '0;
    for (int c = 0; c < 3; c++) begin
      if (store_r[3*c] == '0 && store_r[3*c + 1] == '0 && store_r[3*c + 2] == '0) begin
        prod_nxt.degen = 1'b1;
      end
    end
    for (int r = 0; r < 3; r++) begin
      prod_nxt.pos[r]  = pcomp[r];
      prod_nxt.base[r] = BASE_W'(store_r[9 + r]) + BASE_W'(pcomp[r]);
      for (int c = 0; c < 3; c++) begin
        prod_nxt.ctr_prod[r][c] = PROD_W'(store_r[3*c + r]) * PROD_W'(store_r[12 + c]);
        hp = PROD_W'(abs_comp(store_r[3*c + r])) * PROD_W'(abs_comp(store_r[15 + c]));
        prod_nxt.half_prod[r][c] = hp[HPROD_W-1:0];
      end
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r && s1_is_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r && s1_is_pos) begin
      s2_r <= prod_nxt;
    end
  end

  assign prod_valid_o = s2_valid_r;
  assign prod_o       = s2_r;

endmodule

// ----- hw/rtl/obb_reduce.sv -----
// ----------------------------------------------------------------------------
// obb_reduce: sum, saturate and result register
// Unless degenerate, floors each center product to the fixed-point grid, adds
// translation and position, truncates magnitude products, saturates sums.
// ----------------------------------------------------------------------------
module obb_reduce #(
  parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               prod_valid_i,
  input  obb_pkg::obb_prod_t prod_i,
  output logic               prod_ready_o,
  obb_out_if.source          out_ch
);
  import obb_pkg::*;

  localparam int CW = PROD_W - FRAC_BITS + 2;    // center sum of four terms
  localparam int HW = HPROD_W - FRAC_BITS + 2;   // half sum of three terms

  logic              out_valid_r;
  comp_t             ctr_r  [3];
  logic [HALF_W-1:0] half_r [3];
  logic              degen_r;
  comp_t             ctr_nxt  [3];
  logic [HALF_W-1:0] half_nxt [3];

  assign prod_ready_o = !out_valid_r || out_ch.ready;

  // Row sums with saturation
  always_comb begin
    logic signed [CW-1:0] csum;
    logic [HW-1:0]        hsum;
    logic [HPROD_W-1:0]   hp;
    for (int r = 0; r < 3; r++) begin
      csum = CW'($signed(prod_i.base[r]));
      hsum = '0;
      for (int c = 0; c < 3; c++) begin
        csum = csum + CW'($signed(prod_i.ctr_prod[r][c]) >>> FRAC_BITS);
        hp   = prod_i.half_prod[r][c];
        hsum = hsum + HW'(hp >> FRAC_BITS);
      end
      if (prod_i.degen) begin
        ctr_nxt[r] = $signed(prod_i.pos[r]);
      end else if (csum[CW-1:COMP_W-1] == '0 || csum[CW-1:COMP_W-1] == '1) begin
        ctr_nxt[r] = csum[COMP_W-1:0];
      end else begin
        ctr_nxt[r] = csum[CW-1] ? COMP_MIN : COMP_MAX;
      end
      if (prod_i.degen) begin
        half_nxt[r] = '0;
      end else if (|hsum[HW-1:HALF_W]) begin
        half_nxt[r] = HALF_MAX;
      end else begin
        half_nxt[r] = hsum[HALF_W-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (prod_ready_o) begin
      out_valid_r <= prod_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready_o && prod_valid_i) begin
      for (int r = 0; r < 3; r++) begin
        ctr_r[r]  <= ctr_nxt[r];
        half_r[r] <= half_nxt[r];
      end
      degen_r <= prod_i.degen;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.box_center_x = ctr_r[0];
  assign out_ch.box_center_y = ctr_r[1];
  assign out_ch.box_center_z = ctr_r[2];
  assign out_ch.box_half_x   = half_r[0];
  assign out_ch.box_half_y   = half_r[1];
  assign out_ch.box_half_z   = half_r[2];
  assign out_ch.degenerate   = degen_r;

endmodule

// ----- hw/rtl/oriented_box_to_aabb.sv -----
// Only position beats emit a result, through the input, product and result
// registers; one vector beat is taken per cycle unless the output stalls.
// The 18 products of a box are computed in parallel in one registered stage.
// Reset clears the pipeline valid flags; the vector store is not reset and
// holds no meaning until every stored slot has been written.
// ----------------------------------------------------------------------------
// oriented_box_to_aabb: axis-aligned bound of an oriented box collider
// Collects basis, translation, local center and half extents, then turns a
// position beat into the world center and half extents of the bounding box.
// ----------------------------------------------------------------------------
module oriented_box_to_aabb #(
  parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  obb_in_if.sink     in_ch,
  obb_out_if.source  out_ch
);
  import obb_pkg::*;

  logic      prod_valid;
  logic      prod_ready;
  obb_prod_t prod;

  // Store and multiply
  obb_prod u_prod (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .prod_valid_o (prod_valid),
    .prod_o       (prod),
    .prod_ready_i (prod_ready)
  );

  // Sum, saturate, result register
  obb_reduce #(
    .FRAC_BITS (FRAC_BITS)
  ) u_reduce (
    .clk          (clk),
    .rst_n        (rst_n),
    .prod_valid_i (prod_valid),
    .prod_i       (prod),
    .prod_ready_o (prod_ready),
    .out_ch       (out_ch)
  );

endmodule

// ----- tb/oriented_box_to_aabb_tb.sv -----
// ----------------------------------------------------------------------------
// oriented_box_to_aabb_tb: self-checking bench for the box bound block
// Streams box colliders as slot-tagged vector beats, predicts each world
// bound from a local copy of the vector store and checks every result beat.
// Directed extremes first, then random boxes under four idle/stall phases.
// ----------------------------------------------------------------------------
module oriented_box_to_aabb_tb;
  import obb_pkg::*;

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int BEAT_TARGET  = 1550;
  localparam int MAX_PRINTS   = 20;
  localparam comp_t FX_ONE    = comp_t'(1 << FRAC);

  typedef logic [HALF_W-1:0] half_t;

  typedef struct packed {
    comp_t cx;
    comp_t cy;
    comp_t cz;
    half_t hx;
    half_t hy;
    half_t hz;
    logic  degen;
  } box_t;

  // Scoreboard: mirrors the vector store and holds the boxes still owed
  class box_scoreboard;
    comp_t vec_words [STORE_DEPTH];
    box_t  pending_boxes [$];
    int    mismatches;
    int    boxes_checked;
    int    degenerate_boxes;

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    // World bound of the stored box placed at the given position
    function box_t bound_of_box(comp_t px, comp_t py, comp_t pz);
      comp_t           pos [3];
      box_t            b;
      longint          ctr;
      longint unsigned half;
      longint          m;
      longint          hv;
      longint unsigned am;
      longint unsigned ah;
      logic            degen;
      comp_t           ctr_q [3];
      half_t           half_q [3];
      pos[0] = px;
      pos[1] = py;
      pos[2] = pz;
      degen = 1'b0;
      for (int c = 0; c < 3; c++)
        if (vec_words[3*c] == 0 && vec_words[3*c+1] == 0 && vec_words[3*c+2] == 0)
          degen = 1'b1;
      for (int r = 0; r < 3; r++) begin
        if (degen) begin
          ctr_q[r]  = pos[r];
          half_q[r] = '0;
        end else begin
          ctr  = longint'(vec_words[9+r]) + longint'(pos[r]);
          half = 0;
          for (int c = 0; c < 3; c++) begin
            m    = longint'(vec_words[3*c+r]);
            hv   = longint'(vec_words[15+c]);
            // arithmetic shift floors the product
            ctr  = ctr + ((m * longint'(vec_words[12+c])) >>> FRAC);
            am   = (m < 0) ? -m : m;
            ah   = (hv < 0) ? -hv : hv;
            half = half + ((am * ah) >> FRAC);
          end
          if (ctr > longint'(2147483647))
            ctr_q[r] = comp_t'(COMP_MAX);
          else if (ctr < longint'(comp_t'(COMP_MIN)))
            ctr_q[r] = comp_t'(COMP_MIN);
          else
            ctr_q[r] = comp_t'(ctr[31:0]);
          half_q[r] = (half > 64'd2147483647) ? HALF_MAX : half[HALF_W-1:0];
        end
      end
      b.cx    = ctr_q[0];
      b.cy    = ctr_q[1];
      b.cz    = ctr_q[2];
      b.hx    = half_q[0];
      b.hy    = half_q[1];
      b.hz    = half_q[2];
      b.degen = degen;
      return b;
    endfunction

    // Accepted input beat: store a vector or queue the box it triggers
    function void note_vector(slot_t s, comp_t x, comp_t y, comp_t z);
      box_t b;
      int   base;
      case (s)
        SLOT_POS: begin
          b = bound_of_box(x, y, z);
          pending_boxes.push_back(b);
          if (b.degen)
            degenerate_boxes++;
        end
        SLOT_UNUSED: ;
        default: begin
          base = 3 * int'(s);
          vec_words[base]   = x;
          vec_words[base+1] = y;
          vec_words[base+2] = z;
        end
      endcase
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report(name, got, want);
    endtask

    // Accepted result beat: compare with the oldest owed box
    task check_box(box_t got);
      box_t want;
      if (pending_boxes.size() == 0) begin
        report("box beat with none owed", got.cx, '0);
      end else begin
        want = pending_boxes.pop_front();
        boxes_checked++;
        compare_field("box_center_x", got.cx, want.cx);
        compare_field("box_center_y", got.cy, want.cy);
        compare_field("box_center_z", got.cz, want.cz);
        compare_field("box_half_x", 32'(got.hx), 32'(want.hx));
        compare_field("box_half_y", 32'(got.hy), 32'(want.hy));
        compare_field("box_half_z", 32'(got.hz), 32'(want.hz));
        compare_field("degenerate", 32'(got.degen), 32'(want.degen));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   idle_pct;
  int   stall_pct;
  int   vector_beats;
  int   noise_beats;

  box_scoreboard sb;

  obb_in_if  in_ch ();
  obb_out_if out_ch ();

  oriented_box_to_aabb #(
    .FRAC_BITS (FRAC)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    $display("oriented_box_to_aabb_tb: FAIL");
    $finish;
  end

  // Result side backpressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Beat monitor: inputs noted before results are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_vector(in_ch.slot, in_ch.comp_x, in_ch.comp_y, in_ch.comp_z);
      if (out_ch.valid && out_ch.ready)
        sb.check_box(box_t'({out_ch.box_center_x, out_ch.box_center_y,
                             out_ch.box_center_z, out_ch.box_half_x,
                             out_ch.box_half_y, out_ch.box_half_z,
                             out_ch.degenerate}));
    end
  end

  // One input beat, with a random gap ahead of it
  task automatic send_beat(slot_t s, comp_t x, comp_t y, comp_t z);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.slot   <= s;
    in_ch.comp_x <= x;
    in_ch.comp_y <= y;
    in_ch.comp_z <= z;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    if (s == SLOT_UNUSED)
      noise_beats++;
    else
      vector_beats++;
  endtask

  // Mix of extremes, small fixed-point values and raw words
  function automatic comp_t rand_comp();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4)
      return '0;
    if (pick < 12) begin
      case ($urandom_range(3))
        0: return comp_t'(COMP_MAX);
        1: return comp_t'(COMP_MIN);
        2: return comp_t'(1);
        default: return comp_t'(-1);
      endcase
    end
    if (pick < 55)
      return comp_t'(int'($urandom_range(16 << FRAC)) - (8 << FRAC));
    if (pick < 70)
      return comp_t'(int'($urandom_range(1 << 25)) - (1 << 24));
    return comp_t'($urandom);
  endfunction

  // Random vector for a slot; basis columns sometimes zero or one-hot
  task automatic send_vector(slot_t s);
    int unsigned pick;
    comp_t       v [3];
    pick = $urandom_range(99);
    for (int i = 0; i < 3; i++)
      v[i] = rand_comp();
    if (s <= SLOT_BASIS2 && pick < 6) begin
      v[0] = '0;
      v[1] = '0;
      v[2] = '0;
    end else if (s <= SLOT_BASIS2 && pick < 12) begin
      for (int i = 0; i < 3; i++)
        if (i != int'(pick % 3))
          v[i] = '0;
    end
    send_beat(s, v[0], v[1], v[2]);
  endtask

  // Well-formed box: slots in shuffled order, some left as they were
  task automatic send_box(bit full);
    slot_t order [6];
    slot_t tmp;
    int    j;
    order = '{SLOT_BASIS0, SLOT_BASIS1, SLOT_BASIS2, SLOT_TRANS, SLOT_LCTR, SLOT_HALF};
    for (int i = 5; i > 0; i--) begin
      j = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 6; i++) begin
      if (full || $urandom_range(99) < 60)
        send_vector(order[i]);
      if ($urandom_range(99) < 4)
        send_vector(SLOT_UNUSED);
    end
    send_beat(SLOT_POS, rand_comp(), rand_comp(), rand_comp());
  endtask

  // Stimulus
  initial begin : stimulus
    int    box_idx;
    int    drain_wait;
    slot_t s;
    rst_n        = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    vector_beats = 0;
    noise_beats  = 0;
    in_ch.valid  = 1'b0;
    in_ch.slot   = SLOT_UNUSED;
    in_ch.comp_x = '0;
    in_ch.comp_y = '0;
    in_ch.comp_z = '0;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // unit basis with small offsets; negative half extents fold to positive
    send_beat(SLOT_BASIS0, FX_ONE, 0, 0);
    send_beat(SLOT_BASIS1, 0, FX_ONE, 0);
    send_beat(SLOT_BASIS2, 0, 0, FX_ONE);
    send_beat(SLOT_TRANS, FX_ONE / 2, -FX_ONE, 0);
    send_beat(SLOT_LCTR, 3 * FX_ONE / 2, -2 * FX_ONE, 7);
    send_beat(SLOT_HALF, FX_ONE, -2 * FX_ONE, comp_t'(COMP_MIN));
    send_beat(SLOT_POS, 10 * FX_ONE, -10 * FX_ONE, 0);
    // top of range but for basis 1 and 2: centers and extents clip high
    send_beat(SLOT_BASIS0, COMP_MAX, COMP_MAX, COMP_MAX);
    send_beat(SLOT_TRANS, COMP_MAX, COMP_MAX, COMP_MAX);
    send_beat(SLOT_LCTR, COMP_MAX, COMP_MAX, COMP_MAX);
    send_beat(SLOT_HALF, COMP_MIN, COMP_MIN, COMP_MIN);
    send_beat(SLOT_POS, COMP_MAX, COMP_MAX, COMP_MAX);
    // bottom of range: centers clip low
    send_beat(SLOT_TRANS, COMP_MIN, COMP_MIN, COMP_MIN);
    send_beat(SLOT_LCTR, COMP_MIN, COMP_MIN, COMP_MIN);
    send_beat(SLOT_POS, COMP_MIN, COMP_MIN, COMP_MIN);
    // most negative basis times most negative center
    send_beat(SLOT_BASIS1, COMP_MIN, COMP_MIN, COMP_MIN);
    send_beat(SLOT_POS, 0, 0, 0);
    // zero-length column gives a degenerate box; unused slot in between
    send_beat(SLOT_BASIS2, 0, 0, 0);
    send_beat(SLOT_UNUSED, COMP_MAX, COMP_MIN, -1);
    send_beat(SLOT_POS, COMP_MIN, COMP_MAX, -1);
    // one-LSB products: negative ones floor to -1
    send_beat(SLOT_BASIS0, -1, 1, -1);
    send_beat(SLOT_BASIS1, 1, -1, 1);
    send_beat(SLOT_BASIS2, 0, 0, 1);
    send_beat(SLOT_LCTR, 1, 1, FX_ONE - 1);
    send_beat(SLOT_POS, 0, 0, 0);

    // random boxes, rotating through the idle/stall phases
    box_idx = 0;
    while (vector_beats < BEAT_TARGET) begin
      case ((box_idx / 16) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      case ($urandom_range(99)) inside
        [0:74]: send_box(box_idx % 40 == 0);
        [75:87]: begin
          // broken sequence: stray writes, no position
          repeat ($urandom_range(1, 4)) begin
            s = slot_t'($urandom_range(7));
            if (s == SLOT_POS)
              s = SLOT_UNUSED;
            send_vector(s);
          end
        end
        default: begin
          // back-to-back positions on one stored box
          repeat ($urandom_range(2, 5))
            send_beat(SLOT_POS, rand_comp(), rand_comp(), rand_comp());
        end
      endcase
      box_idx++;
    end
    in_ch.valid <= 1'b0;

    // drain
    drain_wait = 0;
    while (sb.pending_boxes.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_boxes.size() != 0)
      sb.report("boxes never delivered", sb.pending_boxes.size(), 0);

    $display("Sent %0d vector beats and %0d unused-slot beats in %0d cycles.",
             vector_beats, noise_beats, cycle_count);
    $display("Checked %0d boxes (%0d degenerate), %0d mismatches.",
             sb.boxes_checked, sb.degenerate_boxes, sb.mismatches);
    if (sb.mismatches == 0)
      $display("oriented_box_to_aabb_tb: PASS");
    else
      $display("oriented_box_to_aabb_tb: FAIL");
    $finish;
  end

endmodule
